// ----- hdl/rmbm_pkg.sv -----
// shared constants, codes and the decoded request struct of the region mapped byte memory
// no dependencies; used by the interfaces and every module of the block
`timescale 1ns / 1ps
`default_nettype none

package rmbm_pkg;

	localparam int OFFSET_BITS   = 20;
	localparam int REGION_SHIFT  = 20;
	localparam int REGION_W      = 12;
	localparam int DATA_W        = 32;
	localparam int LANES         = 4;

	localparam logic [REGION_W-1:0] REGION_PROGRAM = 12'h004;
	localparam logic [REGION_W-1:0] REGION_DATA    = 12'h100;
	localparam logic [REGION_W-1:0] REGION_STACK   = 12'h7FF;

	// bank index inside the one-hot bank select
	localparam int BANK_PROGRAM = 0;
	localparam int BANK_DATA    = 1;
	localparam int BANK_STACK   = 2;
	localparam int BANKS        = 3;

	localparam logic [1:0] SIZE_BYTE    = 2'd0;
	localparam logic [1:0] SIZE_HALF    = 2'd1;
	localparam logic [1:0] SIZE_WORD    = 2'd2;
	localparam logic [1:0] SIZE_INVALID = 2'd3;

	localparam logic [1:0] ERR_OK       = 2'd0;
	localparam logic [1:0] ERR_UNMAPPED = 2'd1;
	localparam logic [1:0] ERR_SIZE     = 2'd2;

	localparam logic FUNC_READ  = 1'b0;
	localparam logic FUNC_WRITE = 1'b1;

	typedef struct packed {
		logic [BANKS-1:0]  bank_sel;  // one-hot, zero when the access is rejected
		logic              wr;
		logic [LANES-1:0]  be;        // be[j] covers bits 8j+7:8j
		logic [DATA_W-1:0] wdata;     // data already placed on its byte lanes
		logic [1:0]        err;
		logic [1:0]        size;
		logic [1:0]        lane;      // aligned byte offset inside the word
	} req_t;

endpackage

`default_nettype wire

// ----- hdl/rmbm_ifc.sv -----
// valid/ready channel interfaces for the request and response sides
// depends on rmbm_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface rmbm_req_if;
	logic                        valid;
	logic                        ready;
	logic                        func;
	logic [rmbm_pkg::DATA_W-1:0] address;
	logic [rmbm_pkg::DATA_W-1:0] write_data;
	logic [1:0]                  access_size;

	modport source (output valid, func, address, write_data, access_size, input ready);
	modport sink (input valid, func, address, write_data, access_size, output ready);
endinterface

interface rmbm_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [rmbm_pkg::DATA_W-1:0] result_value;
	logic [1:0]                  error_code;

	modport source (output valid, result_value, error_code, input ready);
	modport sink (input valid, result_value, error_code, output ready);
endinterface

`default_nettype wire

// ----- hdl/rmbm_decode.sv -----
// request decode: size and region checks, alignment, byte enables and lane placement
// depends on rmbm_pkg
`timescale 1ns / 1ps
`default_nettype none

module rmbm_decode #(
	parameter int OFFSET_BITS = rmbm_pkg::OFFSET_BITS,
	localparam int ROW_W = (OFFSET_BITS > 2) ? (OFFSET_BITS - 2) : 1
) (
	input  wire logic                        func,
	input  wire logic [rmbm_pkg::DATA_W-1:0] address,
	input  wire logic [rmbm_pkg::DATA_W-1:0] write_data,
	input  wire logic [1:0]                  access_size,
	output rmbm_pkg::req_t                   req,
	output logic [ROW_W-1:0]                 row
);

	logic [rmbm_pkg::REGION_W-1:0] region;
	logic [rmbm_pkg::BANKS-1:0]    sel;

	assign region = address[rmbm_pkg::REGION_SHIFT +: rmbm_pkg::REGION_W];

	// address bits between the offset and the region are ignored
	generate
		if (OFFSET_BITS > 2) begin : g_row
			assign row = address[OFFSET_BITS-1:2];
		end else begin : g_row_one
			assign row = '0;
		end
	endgenerate

	always_comb begin
		unique case (region)
			rmbm_pkg::REGION_PROGRAM: sel = rmbm_pkg::BANKS'(1) << rmbm_pkg::BANK_PROGRAM;
			rmbm_pkg::REGION_DATA:    sel = rmbm_pkg::BANKS'(1) << rmbm_pkg::BANK_DATA;
			rmbm_pkg::REGION_STACK:   sel = rmbm_pkg::BANKS'(1) << rmbm_pkg::BANK_STACK;
			default:                  sel = '0;
		endcase
	end

	always_comb begin
		req.wr   = func == rmbm_pkg::FUNC_WRITE;
		req.size = access_size;
		if (access_size == rmbm_pkg::SIZE_INVALID) begin
			req.err = rmbm_pkg::ERR_SIZE;
		end else if (sel == '0) begin
			req.err = rmbm_pkg::ERR_UNMAPPED;
		end else begin
			req.err = rmbm_pkg::ERR_OK;
		end
		req.bank_sel = (req.err == rmbm_pkg::ERR_OK) ? sel : '0;

		// big-endian: byte offset 0 of a row sits in bits 31:24
		unique case (access_size)
			rmbm_pkg::SIZE_BYTE: begin
				req.lane  = address[1:0];
				req.be    = rmbm_pkg::LANES'(1) << (~address[1:0]);
				req.wdata = {4{write_data[7:0]}};
			end
			rmbm_pkg::SIZE_HALF: begin
				req.lane  = {address[1], 1'b0};
				req.be    = address[1] ? 4'b0011 : 4'b1100;
				req.wdata = {2{write_data[15:0]}};
			end
			rmbm_pkg::SIZE_WORD: begin
				req.lane  = 2'b00;
				req.be    = 4'b1111;
				req.wdata = write_data;
			end
			default: begin
				req.lane  = 2'b00;
				req.be    = 4'b0000;
				req.wdata = write_data;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- hdl/rmbm_bank.sv -----
// one byte store, organized as 32-bit rows with per-byte write enables
// depends on rmbm_pkg
`timescale 1ns / 1ps
`default_nettype none

module rmbm_bank #(
	parameter int OFFSET_BITS = rmbm_pkg::OFFSET_BITS,
	localparam int ROW_W = (OFFSET_BITS > 2) ? (OFFSET_BITS - 2) : 1,
	localparam int ROWS  = 1 << (OFFSET_BITS - 2)
) (
	input  wire logic                        clk,
	input  wire logic                        we,
	input  wire logic                        re,
	input  wire logic [rmbm_pkg::LANES-1:0]  be,
	input  wire logic [ROW_W-1:0]            addr,
	input  wire logic [rmbm_pkg::DATA_W-1:0] wdata,
	output logic [rmbm_pkg::DATA_W-1:0]      rdata_q
);

	logic [rmbm_pkg::DATA_W-1:0] mem [ROWS];

	always_ff @(posedge clk) begin
		if (we) begin
			for (int j = 0; j < rmbm_pkg::LANES; j++) begin
				if (be[j]) begin
					mem[addr][8*j +: 8] <= wdata[8*j +: 8];
				end
			end
		end
	end

	// read data only moves on a read, so a stalled stage keeps its word
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/region_mapped_byte_memory.sv -----
// top level: request decode, three banks, one request stage and the response register
// depends on rmbm_pkg, rmbm_ifc, rmbm_decode and rmbm_bank
//
//   channel  dir  signals                                        width
//   req      in   valid ready func address write_data access_size 1/32/32/2
//   rsp      out  valid ready result_value error_code             32/2
//
// one transaction per cycle unless stalled; the request stage feeds the response register
// after reset a clearing pass zeroes one 32-bit row of every bank per cycle,
//   across all 2**(OFFSET_BITS-2) rows (262144 at OFFSET_BITS = 20), req.ready low meanwhile
// a stalled response holds the request stage; req.ready follows rsp.ready through it
// bank reads and writes happen at the edge a request is taken, so order is kept
`timescale 1ns / 1ps
`default_nettype none

module region_mapped_byte_memory #(
	parameter int OFFSET_BITS = rmbm_pkg::OFFSET_BITS
) (
	input wire logic  clk,
	input wire logic  arst_n,
	rmbm_req_if.sink  req,
	rmbm_rsp_if.source rsp
);

	localparam int ROW_W = (OFFSET_BITS > 2) ? (OFFSET_BITS - 2) : 1;
	localparam int ROWS  = 1 << (OFFSET_BITS - 2);

	rmbm_pkg::req_t  dec;
	logic [ROW_W-1:0] dec_row;
	logic             accept;
	logic             advance;

	logic             clearing_q;
	logic [ROW_W-1:0] clr_row_q;

	logic [rmbm_pkg::DATA_W-1:0] bank_rdata [rmbm_pkg::BANKS];

	logic                        v_s1;
	logic                        wr_s1;
	logic [1:0]                  err_s1;
	logic [1:0]                  size_s1;
	logic [1:0]                  lane_s1;
	logic [rmbm_pkg::BANKS-1:0]  sel_s1;

	logic [rmbm_pkg::DATA_W-1:0] word;
	logic [rmbm_pkg::DATA_W-1:0] byte_word;
	logic [rmbm_pkg::DATA_W-1:0] result;

	logic                        out_valid_q;
	logic [rmbm_pkg::DATA_W-1:0] result_q;
	logic [1:0]                  err_q;

	rmbm_decode #(.OFFSET_BITS(OFFSET_BITS)) u_decode (
		.func        (req.func),
		.address     (req.address),
		.write_data  (req.write_data),
		.access_size (req.access_size),
		.req         (dec),
		.row         (dec_row)
	);

	assign advance   = v_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !clearing_q && (!v_s1 || advance);
	assign accept    = req.valid && req.ready;

	generate
		for (genvar b = 0; b < rmbm_pkg::BANKS; b++) begin : g_bank
			rmbm_bank #(.OFFSET_BITS(OFFSET_BITS)) u_bank (
				.clk     (clk),
				.we      (clearing_q || (accept && dec.wr && dec.bank_sel[b])),
				.re      (accept && !dec.wr && dec.bank_sel[b]),
				.be      (clearing_q ? {rmbm_pkg::LANES{1'b1}} : dec.be),
				.addr    (clearing_q ? clr_row_q : dec_row),
				.wdata   (clearing_q ? '0 : dec.wdata),
				.rdata_q (bank_rdata[b])
			);
		end
	endgenerate

	// clearing pass over all rows after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_row_q  <= '0;
		end else if (clearing_q) begin
			clr_row_q <= clr_row_q + 1'b1;
			if (clr_row_q == ROW_W'(ROWS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (advance) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			wr_s1   <= dec.wr;
			err_s1  <= dec.err;
			size_s1 <= dec.size;
			lane_s1 <= dec.lane;
			sel_s1  <= dec.bank_sel;
		end
	end

	always_comb begin
		word = '0;
		for (int b = 0; b < rmbm_pkg::BANKS; b++) begin
			if (sel_s1[b]) begin
				word = bank_rdata[b];
			end
		end
	end

	assign byte_word = word >> {~lane_s1, 3'b000};

	always_comb begin
		if (err_s1 != rmbm_pkg::ERR_OK) begin
			result = '0;
		end else if (wr_s1) begin
			result = rmbm_pkg::DATA_W'(1);
		end else begin
			case (size_s1)
				rmbm_pkg::SIZE_BYTE: result = {24'd0, byte_word[7:0]};
				rmbm_pkg::SIZE_HALF: result = {16'd0, lane_s1[1] ? word[15:0] : word[31:16]};
				default:             result = word;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
			err_q    <= err_s1;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.result_value = result_q;
	assign rsp.error_code   = err_q;

	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !req.ready)
		else $error("request taken during clearing pass");

	a_clear_full_pass: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clearing_q) |-> $past(clr_row_q) == ROW_W'(ROWS - 1))
		else $error("clearing pass ended early");

	a_one_bank: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> $onehot0(sel_s1) && ((sel_s1 == '0) == (err_s1 != rmbm_pkg::ERR_OK)))
		else $error("bank select disagrees with error code");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.error_code != rmbm_pkg::ERR_OK |-> rsp.result_value == '0)
		else $error("rejected access returned nonzero data");

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> v_s1)
		else $error("accepted request lost from stage one");

endmodule

`default_nettype wire
